/* rtl/core/ber_tlv_header_parser_defines.svh */
// ----------------------------------------------------------------------------
// BER TLV header parser assertion macros
// Shared macros for the concurrent checks on the parser ports.
// ----------------------------------------------------------------------------
`ifndef BER_TLV_HEADER_PARSER_DEFINES_SVH
`define BER_TLV_HEADER_PARSER_DEFINES_SVH

// Checked only while reset is released.
`define BERTLV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("BER TLV parser check failed");

// Checked at every edge, including during reset.
`define BERTLV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("BER TLV parser reset check failed");

`endif

/* rtl/core/bertlv_pkg.sv */
// ----------------------------------------------------------------------------
// BER TLV header parser package
// Request types, result codes and limits shared by the parser and its checker.
// ----------------------------------------------------------------------------
package bertlv_pkg;

  localparam int unsigned MAX_TAG_BYTES    = 4;
  localparam int unsigned MAX_LENGTH_BYTES = 4;

  localparam logic [4:0] TAG_LOW_ESCAPE = 5'h1f;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_CONTENT = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_LENGTH    = 2'd1,
    ERR_TAG_LONG  = 2'd2,
    ERR_TRUNCATED = 2'd3
  } err_e;

  typedef enum logic [4:0] {
    PH_IDENT   = 5'b00001,
    PH_TAG     = 5'b00010,
    PH_LEN0    = 5'b00100,
    PH_LENX    = 5'b01000,
    PH_CONTENT = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  tag_class;
    logic        constructed;
    logic [27:0] tag_number;
    logic [31:0] content_length;
    logic [3:0]  header_length;
    logic [7:0]  content_byte;
    logic        element_end;
    err_e        error_code;
  } out_item_t;

endpackage

/* rtl/core/ber_tlv_header_parser.sv */
// The result of an accepted byte is registered in the output register.
// Throughput: one byte per cycle unless stalled; state updates in a single pass.
// A byte is refused only while a result is held and the output is stalled.
// Reset is asynchronous and returns the parser to awaiting an identifier byte.
// ----------------------------------------------------------------------------
// BER TLV header parser
// Splits a BER byte stream into header, content and error results.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser
  import bertlv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  class_q, class_d;
  logic        cons_q, cons_d;
  logic [27:0] tag_q, tag_d;
  logic [2:0]  tag_seen_q, tag_seen_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [31:0] len_q, len_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] content_left_q, content_left_d;

  logic        out_valid_q;
  out_item_t   out_q, res_d;
  logic        emit;
  logic        accept;
  logic        clear;
  logic [7:0]  b;
  logic [6:0]  n_len;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign b          = in_data_i.data_byte;
  assign n_len      = b[6:0];

  always_comb begin
    phase_d        = phase_q;
    class_d        = class_q;
    cons_d         = cons_q;
    tag_d          = tag_q;
    tag_seen_d     = tag_seen_q;
    len_left_d     = len_left_q;
    len_d          = len_q;
    hdr_cnt_d      = hdr_cnt_q;
    content_left_d = content_left_q;
    emit           = 1'b0;
    clear          = 1'b0;
    res_d          = '0;

    if (in_data_i.stream_end) begin
      if (phase_q != PH_IDENT) begin
        emit             = 1'b1;
        clear            = 1'b1;
        res_d.kind       = KIND_ERROR;
        res_d.error_code = ERR_TRUNCATED;
      end
    end else begin
      case (phase_q)
        PH_IDENT: begin
          class_d    = b[7:6];
          cons_d     = b[5];
          tag_seen_d = '0;
          hdr_cnt_d  = 4'd1;
          if (b[4:0] == TAG_LOW_ESCAPE) begin
            tag_d   = '0;
            phase_d = PH_TAG;
          end else begin
            tag_d   = {23'd0, b[4:0]};
            phase_d = PH_LEN0;
          end
        end
        PH_TAG: begin
          tag_seen_d = tag_seen_q + 3'd1;
          hdr_cnt_d  = hdr_cnt_q + 4'd1;
          tag_d      = {tag_q[20:0], b[6:0]};
          if (b[7]) begin
            if (tag_seen_d >= 3'(MAX_TAG_BYTES)) begin
              emit             = 1'b1;
              clear            = 1'b1;
              res_d.kind       = KIND_ERROR;
              res_d.error_code = ERR_TAG_LONG;
            end
          end else begin
            phase_d = PH_LEN0;
          end
        end
        PH_LEN0: begin
          hdr_cnt_d = hdr_cnt_q + 4'd1;
          if (!b[7]) begin
            len_d = {24'd0, b};
            emit  = 1'b1;
          end else if (n_len == 7'd0 || n_len > 7'(MAX_LENGTH_BYTES)) begin
            emit             = 1'b1;
            clear            = 1'b1;
            res_d.kind       = KIND_ERROR;
            res_d.error_code = ERR_LENGTH;
          end else begin
            len_left_d = n_len[2:0];
            len_d      = '0;
            phase_d    = PH_LENX;
          end
        end
        PH_LENX: begin
          hdr_cnt_d  = hdr_cnt_q + 4'd1;
          len_d      = {len_q[23:0], b};
          len_left_d = len_left_q - 3'd1;
          if (len_left_d == 3'd0) begin
            emit = 1'b1;
          end
        end
        PH_CONTENT: begin
          content_left_d = content_left_q - 32'd1;
          emit           = 1'b1;
        end
        default: begin
          clear = 1'b1;
        end
      endcase

      if (emit && res_d.kind != KIND_ERROR && phase_q != PH_CONTENT) begin
        res_d.kind           = KIND_HEADER;
        res_d.tag_class      = class_d;
        res_d.constructed    = cons_d;
        res_d.tag_number     = tag_d;
        res_d.content_length = len_d;
        res_d.header_length  = hdr_cnt_d;
        res_d.element_end    = (len_d == 32'd0);
        res_d.error_code     = ERR_NONE;
        content_left_d       = len_d;
        if (len_d == 32'd0) begin
          clear = 1'b1;
        end else begin
          phase_d = PH_CONTENT;
        end
      end else if (emit && res_d.kind != KIND_ERROR) begin
        res_d.kind           = KIND_CONTENT;
        res_d.tag_class      = class_q;
        res_d.constructed    = cons_q;
        res_d.tag_number     = tag_q;
        res_d.content_length = len_q;
        res_d.header_length  = hdr_cnt_q;
        res_d.content_byte   = b;
        res_d.element_end    = (content_left_d == 32'd0);
        res_d.error_code     = ERR_NONE;
        if (content_left_d == 32'd0) begin
          clear = 1'b1;
        end
      end
    end

    if (clear) begin
      phase_d        = PH_IDENT;
      class_d        = '0;
      cons_d         = 1'b0;
      tag_d          = '0;
      tag_seen_d     = '0;
      len_left_d     = '0;
      len_d          = '0;
      hdr_cnt_d      = '0;
      content_left_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDENT;
      class_q        <= '0;
      cons_q         <= 1'b0;
      tag_q          <= '0;
      tag_seen_q     <= '0;
      len_left_q     <= '0;
      len_q          <= '0;
      hdr_cnt_q      <= '0;
      content_left_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        phase_q        <= phase_d;
        class_q        <= class_d;
        cons_q         <= cons_d;
        tag_q          <= tag_d;
        tag_seen_q     <= tag_seen_d;
        len_left_q     <= len_left_d;
        len_q          <= len_d;
        hdr_cnt_q      <= hdr_cnt_d;
        content_left_q <= content_left_d;
        out_valid_q    <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/core/bertlv_checker.sv */
// ----------------------------------------------------------------------------
// BER TLV header parser checker
// Port-level checks on the parser outputs, bound into the parser module.
// ----------------------------------------------------------------------------
`include "ber_tlv_header_parser_defines.svh"

module bertlv_checker
  import bertlv_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic in_seen;

  assign in_seen = in_valid_i | in_stall_o | in_data_i.stream_end;

  `BERTLV_ASSERT_ALWAYS(a_reset_clears_output, clk_i, !rst_ni |-> !out_valid_o)

  `BERTLV_ASSERT(a_stalled_result_holds, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  `BERTLV_ASSERT(a_error_fields_zero, clk_i, rst_ni, out_valid_o && out_data_o.kind == KIND_ERROR |-> out_data_o.tag_number == 28'd0 && out_data_o.content_length == 32'd0 && out_data_o.header_length == 4'd0 && out_data_o.element_end == 1'b0 && out_data_o.error_code != ERR_NONE)

  `BERTLV_ASSERT(a_header_end_mark, clk_i, rst_ni, out_valid_o && out_data_o.kind == KIND_HEADER |-> out_data_o.content_byte == 8'd0 && out_data_o.error_code == ERR_NONE && out_data_o.header_length >= 4'd2 && (out_data_o.element_end == (out_data_o.content_length == 32'd0)))

  `BERTLV_ASSERT(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o && in_seen |-> !in_stall_o)

endmodule

bind ber_tlv_header_parser bertlv_checker u_bertlv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
